/* hdl/sliding_window_flood_detector_macros.svh */
// Assertion macros for the sliding window flood detector checker.
// No dependencies; included by the checker file only.
`ifndef SLIDING_WINDOW_FLOOD_DETECTOR_MACROS_SVH
`define SLIDING_WINDOW_FLOOD_DETECTOR_MACROS_SVH

// Same-cycle implication, clocked on i_clk, idle in reset.
`define SWFD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("flood detector assertion failed");

// Next-cycle implication, clocked on i_clk, idle in reset.
`define SWFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("flood detector assertion failed");

`endif

/* hdl/swfd_pkg.sv */
// Shared constants and types of the sliding window flood detector.
// No dependencies.
package swfd_pkg;
    localparam int FLOWS    = 64;
    localparam int HISTORY  = 16;
    localparam int FLOW_W   = $clog2(FLOWS);
    localparam int POS_W    = $clog2(HISTORY);
    localparam int CNT_W    = $clog2(HISTORY + 1);
    localparam int STAMP_AW = $clog2(FLOWS * HISTORY);

    localparam logic       FUNC_MSG   = 1'b0;
    localparam logic       FUNC_SWEEP = 1'b1;
    localparam logic [0:0] CFG_WINDOW = 1'b0;
    localparam logic [0:0] CFG_MAXMSG = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] sender_key;
        logic [31:0] target_key;
        logic [1:0]  msg_class;
        logic [31:0] now_seconds;
    } t_item;

    typedef struct packed {
        logic       flooding;
        logic [4:0] window_count;
        logic       not_recorded;
    } t_result;
endpackage

/* hdl/swfd_front.sv */
// Front end: accepts items and holds them in a two-entry queue.
// Depends on swfd_pkg.
module swfd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  swfd_pkg::t_item i_item,
    output logic            o_q_valid,
    output swfd_pkg::t_item o_q_item,
    input  logic            i_q_pop
);
    import swfd_pkg::*;

    t_item      r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) n_cnt = r_cnt + 2'd1;
        else if (pop && !push) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wr <= !r_wr;
            if (pop)  r_rd <= !r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_item;
    end
endmodule

/* hdl/swfd_engine.sv */
// Back end: flow lookup, ring pruning, append and sweep sequencer.
// Depends on swfd_pkg; holds the flow key, ring state and stamp memories.
module swfd_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  swfd_pkg::t_item  i_q_item,
    output logic             o_q_pop,
    input  logic [15:0]      i_window,
    input  logic [3:0]       i_max_msgs,
    output logic             o_res_valid,
    output swfd_pkg::t_result o_res,
    input  logic             i_res_take
);
    import swfd_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LK_RD  = 4'd1;
    localparam logic [3:0] S_LK_CMP = 4'd2;
    localparam logic [3:0] S_MT_RD  = 4'd3;
    localparam logic [3:0] S_MT_WT  = 4'd4;
    localparam logic [3:0] S_PR_RD  = 4'd5;
    localparam logic [3:0] S_PR_CMP = 4'd6;
    localparam logic [3:0] S_PR_END = 4'd7;
    localparam logic [3:0] S_APPEND = 4'd8;
    localparam logic [3:0] S_WB     = 4'd9;
    localparam logic [3:0] S_SW_CHK = 4'd10;
    localparam logic [3:0] S_SW_NXT = 4'd11;
    localparam logic [3:0] S_RESULT = 4'd12;

    localparam logic [FLOW_W-1:0] LAST_FLOW = FLOW_W'(FLOWS - 1);
    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(HISTORY - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(HISTORY);

    logic [3:0]          r_state;
    t_item               r_item;
    logic [FLOW_W-1:0]   r_f;
    logic                r_free_found;
    logic [FLOW_W-1:0]   r_free;
    logic [POS_W-1:0]    r_head;
    logic [CNT_W-1:0]    r_cnt;
    logic [FLOWS-1:0]    r_valid;
    t_result             r_res;

    // memories
    logic [65:0]           r_key_mem [FLOWS];
    logic [65:0]           r_key_q;
    logic [POS_W+CNT_W-1:0] r_meta_mem [FLOWS];
    logic [POS_W+CNT_W-1:0] r_meta_q;
    logic [31:0]           r_stamp_mem [FLOWS*HISTORY];
    logic [31:0]           r_stamp_q;

    logic [65:0]        item_key;
    logic               hit;
    logic               free_here;
    logic [31:0]        age;
    logic [POS_W-1:0]   head_inc;
    logic [POS_W:0]     pos_sum;
    logic [POS_W-1:0]   tail_pos;
    logic [POS_W-1:0]   stamp_pos;
    logic [STAMP_AW-1:0] stamp_addr;
    logic [STAMP_AW:0]   stamp_full;
    logic               stamp_we;

    assign item_key  = {r_item.sender_key, r_item.target_key, r_item.msg_class};
    assign hit       = r_valid[r_f] && (r_key_q == item_key);
    assign free_here = !r_valid[r_f];
    assign age       = r_item.now_seconds - r_stamp_q;
    assign head_inc  = (r_head == LAST_POS) ? '0 : r_head + POS_W'(1);
    assign pos_sum   = {1'b0, r_head} + (POS_W+1)'(r_cnt);
    assign tail_pos  = (pos_sum >= (POS_W+1)'(HISTORY))
                     ? POS_W'(pos_sum - (POS_W+1)'(HISTORY)) : pos_sum[POS_W-1:0];
    assign stamp_pos = ((r_state == S_APPEND) && (r_cnt != FULL_CNT)) ? tail_pos : r_head;
    assign stamp_full = (STAMP_AW+1)'(r_f) * (STAMP_AW+1)'(HISTORY)
                      + (STAMP_AW+1)'(stamp_pos);
    assign stamp_addr = stamp_full[STAMP_AW-1:0];
    assign stamp_we   = (r_state == S_APPEND);

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (r_state == S_LK_RD) r_key_q <= r_key_mem[r_f];
        if ((r_state == S_LK_CMP) && !hit && (r_f == LAST_FLOW)
                && (r_free_found || free_here))
            r_key_mem[r_free_found ? r_free : r_f] <= item_key;
        if (r_state == S_MT_RD) r_meta_q <= r_meta_mem[r_f];
        if ((r_state == S_WB) || ((r_state == S_PR_END) && r_item.func == FUNC_SWEEP))
            r_meta_mem[r_f] <= {r_head, r_cnt};
        if (r_state == S_PR_RD) r_stamp_q <= r_stamp_mem[stamp_addr];
        if (stamp_we) r_stamp_mem[stamp_addr] <= r_item.now_seconds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_free_found <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item       <= i_q_item;
                        r_f          <= '0;
                        r_free_found <= 1'b0;
                        r_state <= (i_q_item.func == FUNC_SWEEP) ? S_SW_CHK : S_LK_RD;
                    end
                end
                S_LK_RD: r_state <= S_LK_CMP;
                S_LK_CMP: begin
                    if (free_here && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free       <= r_f;
                    end
                    if (hit) begin
                        r_state <= S_MT_RD;
                    end else if (r_f != LAST_FLOW) begin
                        r_f     <= r_f + FLOW_W'(1);
                        r_state <= S_LK_RD;
                    end else if (r_free_found || free_here) begin
                        r_f <= r_free_found ? r_free : r_f;
                        r_valid[r_free_found ? r_free : r_f] <= 1'b1;
                        r_head  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_APPEND;
                    end else begin
                        r_res   <= '{flooding: 1'b0, window_count: 5'd0, not_recorded: 1'b1};
                        r_state <= S_RESULT;
                    end
                end
                S_MT_RD: r_state <= S_MT_WT;
                S_MT_WT: begin
                    r_head  <= r_meta_q[POS_W+CNT_W-1:CNT_W];
                    r_cnt   <= r_meta_q[CNT_W-1:0];
                    r_state <= S_PR_RD;
                end
                S_PR_RD: r_state <= (r_cnt == '0) ? S_PR_END : S_PR_CMP;
                S_PR_CMP: begin
                    if (age >= {16'd0, i_window}) begin
                        r_head  <= head_inc;
                        r_cnt   <= r_cnt - CNT_W'(1);
                        r_state <= S_PR_RD;
                    end else begin
                        r_state <= S_PR_END;
                    end
                end
                S_PR_END: begin
                    if (r_item.func == FUNC_SWEEP) begin
                        if (r_cnt == '0) r_valid[r_f] <= 1'b0;
                        r_state <= S_SW_NXT;
                    end else begin
                        r_state <= S_APPEND;
                    end
                end
                S_APPEND: begin
                    // overwrite the oldest stamp when the ring is full
                    if (r_cnt == FULL_CNT) r_head <= head_inc;
                    else r_cnt <= r_cnt + CNT_W'(1);
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_res.flooding     <= (r_cnt > CNT_W'(i_max_msgs));
                    r_res.window_count <= 5'(r_cnt);
                    r_res.not_recorded <= 1'b0;
                    r_state <= S_RESULT;
                end
                S_SW_CHK: r_state <= r_valid[r_f] ? S_MT_RD : S_SW_NXT;
                S_SW_NXT: begin
                    if (r_f == LAST_FLOW) begin
                        r_res   <= '0;
                        r_state <= S_RESULT;
                    end else begin
                        r_f     <= r_f + FLOW_W'(1);
                        r_state <= S_SW_CHK;
                    end
                end
                S_RESULT: if (i_res_take) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* hdl/sliding_window_flood_detector.sv */
// Top level of the sliding window flood detector: config registers, output register.
// Depends on swfd_pkg, swfd_front and swfd_engine.
//
// Usage:
//   Input channel: i_valid / o_stall carry one item (func, keys, class, time).
//   A transfer happens on a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall carry exactly one result per item.
//   Items wait in a two-entry queue, so the sender keeps moving while the
//   sequencer works on an earlier item.
//   A message walks the flow table one flow at a time, each through a
//   registered key memory read (S_LK_RD, S_LK_CMP), then reads and checks
//   stamps while pruning (S_PR_RD, S_PR_CMP), then appends and writes back.
//   A sweep skips a free flow and on a live one reads the ring state and
//   prunes its stamps, dropping the flow when its ring is empty.
//   Throughput is one item per lookup or sweep, set by the flow table walk.
//   Reset (synchronous, active low) clears all flow valid marks, the queue
//   and the output register, and loads window 8 s and limit 4.
//   When the receiver stalls, hold the result in the output register; the
//   sequencer waits with the next result until the register frees.
//   Write configuration only while the block is idle.
module sliding_window_flood_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [31:0] i_sender_key,
    input  logic [31:0] i_target_key,
    input  logic [1:0]  i_msg_class,
    input  logic [31:0] i_now_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_flooding,
    output logic [4:0]  o_window_count,
    output logic        o_not_recorded,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import swfd_pkg::*;

    logic [15:0] r_window;
    logic [3:0]  r_max_msgs;
    logic        r_out_valid;
    t_result     r_out;

    t_item   in_item, q_item;
    logic    q_valid, q_pop;
    logic    res_valid, res_take;
    t_result res;

    assign in_item = '{func: i_func, sender_key: i_sender_key, target_key: i_target_key,
                       msg_class: i_msg_class, now_seconds: i_now_seconds};

    swfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    swfd_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .i_window    (r_window),
        .i_max_msgs  (r_max_msgs),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // Load the output register when it is empty or being drained.
    assign res_take = res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= 16'd8;
            r_max_msgs  <= 4'd4;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW: r_window   <= i_cfg_data;
                    CFG_MAXMSG: r_max_msgs <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (res_take) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) r_out <= res;
    end

    assign o_valid        = r_out_valid;
    assign o_flooding     = r_out.flooding;
    assign o_window_count = r_out.window_count;
    assign o_not_recorded = r_out.not_recorded;
endmodule

/* hdl/swfd_checker.sv */
// Port-level checker for the sliding window flood detector, bound to the top.
// Depends on sliding_window_flood_detector_macros.svh.
`include "sliding_window_flood_detector_macros.svh"

module swfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_flooding,
    input logic [4:0]  o_window_count,
    input logic        o_not_recorded
);
    `SWFD_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_window_count))
    `SWFD_ASSERT_NOW(a_drop_empty, o_valid && o_not_recorded,
        !o_flooding && (o_window_count == 5'd0))
    `SWFD_ASSERT_NOW(a_count_range, o_valid, o_window_count <= 5'd16)
    `SWFD_ASSERT_NOW(a_flood_count, o_valid && o_flooding, o_window_count != 5'd0)
endmodule

bind sliding_window_flood_detector swfd_checker u_swfd_checker (.*);
